// ----- hdl/gtw_pkg.sv -----
// Shared types, constants and the 5x7 column font for the glyph writer.
// No dependencies; every other file of the block but gtw_fifo uses this package.
`default_nettype none

package gtw_pkg;

    localparam int GLYPH_SCALE_DEF = 2;
    localparam int COORD_BITS_DEF  = 14;

    localparam int FIELD_BITS     = 14;
    localparam int ROW_BITS       = 14;
    localparam int COLOR_BITS     = 32;
    localparam int CODE_BITS      = 8;
    localparam int DIM_BITS       = 13;
    localparam int GLYPH_COLS     = 5;
    localparam int GLYPH_ROWS     = 7;
    localparam int GLYPH_COL_BITS = 8;
    localparam int GLYPH_BITS     = GLYPH_COLS * GLYPH_COL_BITS;
    localparam int FONT_IDX_BITS  = 6;
    localparam int QUEUE_DEPTH    = 2;

    localparam int APB_ADDR_BITS  = 3;
    localparam int APB_DATA_BITS  = 32;

    localparam logic [CODE_BITS-1:0] FONT_FIRST = 8'd32;
    localparam logic [CODE_BITS-1:0] FONT_END   = 8'd96;
    localparam logic [CODE_BITS-1:0] LOWER_A    = 8'h61;
    localparam logic [CODE_BITS-1:0] LOWER_Z    = 8'h7A;
    localparam logic [CODE_BITS-1:0] CASE_FOLD  = 8'd32;

    localparam logic [DIM_BITS-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [DIM_BITS-1:0] FRAME_HEIGHT_RST = 13'd480;

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [DIM_BITS-1:0] width;
        logic [DIM_BITS-1:0] height;
    } frame_cfg_t;

    // Five column bytes, first column in the top byte. Bit k of a column is glyph row k.
    function automatic logic [GLYPH_BITS-1:0] font_glyph(input logic [FONT_IDX_BITS-1:0] idx);
        logic [GLYPH_BITS-1:0] g;
        unique case (idx)
            6'd0:  g = 40'h0000000000;
            6'd1:  g = 40'h00005F0000;
            6'd2:  g = 40'h0007000700;
            6'd3:  g = 40'h147F147F14;
            6'd4:  g = 40'h242A7F2A12;
            6'd5:  g = 40'h2313086462;
            6'd6:  g = 40'h3649552250;
            6'd7:  g = 40'h0005030000;
            6'd8:  g = 40'h001C224100;
            6'd9:  g = 40'h0041221C00;
            6'd10: g = 40'h14083E0814;
            6'd11: g = 40'h08083E0808;
            6'd12: g = 40'h0050300000;
            6'd13: g = 40'h0808080808;
            6'd14: g = 40'h0060600000;
            6'd15: g = 40'h2010080402;
            6'd16: g = 40'h3E5149453E;
            6'd17: g = 40'h00427F4000;
            6'd18: g = 40'h4261514946;
            6'd19: g = 40'h2141454B31;
            6'd20: g = 40'h1814127F10;
            6'd21: g = 40'h2745454539;
            6'd22: g = 40'h3C4A494930;
            6'd23: g = 40'h0171090503;
            6'd24: g = 40'h3649494936;
            6'd25: g = 40'h064949291E;
            6'd26: g = 40'h0036360000;
            6'd27: g = 40'h0056360000;
            6'd28: g = 40'h0814224100;
            6'd29: g = 40'h1414141414;
            6'd30: g = 40'h0041221408;
            6'd31: g = 40'h0201510906;
            6'd32: g = 40'h324979413E;
            6'd33: g = 40'h7E1111117E;
            6'd34: g = 40'h7F49494936;
            6'd35: g = 40'h3E41414122;
            6'd36: g = 40'h7F4141221C;
            6'd37: g = 40'h7F49494941;
            6'd38: g = 40'h7F09090901;
            6'd39: g = 40'h3E4149497A;
            6'd40: g = 40'h7F0808087F;
            6'd41: g = 40'h00417F4100;
            6'd42: g = 40'h2040413F01;
            6'd43: g = 40'h7F08142241;
            6'd44: g = 40'h7F40404040;
            6'd45: g = 40'h7F020C027F;
            6'd46: g = 40'h7F0408107F;
            6'd47: g = 40'h3E4141413E;
            6'd48: g = 40'h7F09090906;
            6'd49: g = 40'h3E4151215E;
            6'd50: g = 40'h7F09192946;
            6'd51: g = 40'h4649494931;
            6'd52: g = 40'h01017F0101;
            6'd53: g = 40'h3F4040403F;
            6'd54: g = 40'h1F2040201F;
            6'd55: g = 40'h3F4038403F;
            6'd56: g = 40'h6314081463;
            6'd57: g = 40'h0708700807;
            6'd58: g = 40'h6151494543;
            6'd59: g = 40'h007F414100;
            6'd60: g = 40'h0204081020;
            6'd61: g = 40'h0041417F00;
            6'd62: g = 40'h0402010204;
            6'd63: g = 40'h4040404040;
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/gtw_if.sv -----
// Valid/ready channel interfaces: character requests in, column requests out.
// Depends on gtw_pkg for the field widths.
`default_nettype none

interface gtw_char_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   start_of_line;
    logic signed [gtw_pkg::FIELD_BITS-1:0]  start_x;
    logic signed [gtw_pkg::FIELD_BITS-1:0]  start_y;
    logic        [gtw_pkg::CODE_BITS-1:0]   char_code;
    logic        [gtw_pkg::COLOR_BITS-1:0]  pixel_color;

    modport source (output valid, start_of_line, start_x, start_y, char_code, pixel_color,
                    input ready);
    modport sink   (input valid, start_of_line, start_x, start_y, char_code, pixel_color,
                    output ready);
endinterface

interface gtw_col_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [gtw_pkg::FIELD_BITS-1:0]  column_x;
    logic signed [gtw_pkg::FIELD_BITS-1:0]  column_top_y;
    logic        [gtw_pkg::ROW_BITS-1:0]    row_mask;
    logic        [gtw_pkg::COLOR_BITS-1:0]  paint_color;
    logic                                   last_column;

    modport source (output valid, column_x, column_top_y, row_mask, paint_color, last_column,
                    input ready);
    modport sink   (input valid, column_x, column_top_y, row_mask, paint_color, last_column,
                    output ready);
endinterface

`default_nettype wire

// ----- hdl/gtw_front.sv -----
// Front end: accepts characters, keeps the cursor, folds case, fetches the glyph
// and precomputes the row clip mask. Depends on gtw_pkg and gtw_if.
`default_nettype none

module gtw_front #(
    parameter int GLYPH_SCALE = gtw_pkg::GLYPH_SCALE_DEF,
    parameter int COORD_BITS  = gtw_pkg::COORD_BITS_DEF,
    parameter int ENTRY_W     = 1
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    gtw_char_if.sink                in_chan,
    input  wire gtw_pkg::frame_cfg_t cfg,
    input  wire logic               full,
    output logic                    push,
    output logic [ENTRY_W-1:0]      push_data
);
    import gtw_pkg::*;

    localparam int XW = ((COORD_BITS > FIELD_BITS) ? COORD_BITS : FIELD_BITS) + 2;
    localparam logic signed [XW-1:0] C_MAX   = XW'((1 << (COORD_BITS - 1)) - 1);
    localparam logic signed [XW-1:0] C_MIN   = XW'(-(1 << (COORD_BITS - 1)));
    localparam logic signed [XW-1:0] F_MAX   = XW'((1 << (FIELD_BITS - 1)) - 1);
    localparam logic signed [XW-1:0] F_MIN   = XW'(-(1 << (FIELD_BITS - 1)));
    localparam logic signed [XW-1:0] ADVANCE = XW'((GLYPH_COLS + 1) * GLYPH_SCALE);

    logic signed [COORD_BITS-1:0] cursor_x_reg, cursor_x_next;
    logic signed [COORD_BITS-1:0] cursor_y_reg, cursor_y_next;
    logic signed [XW-1:0]         sx_ext, sy_ext, cx_ext, cy_ext, height_ext;
    logic [CODE_BITS-1:0]         code_fold;
    logic                         drawn;
    logic                         accept;
    logic [FONT_IDX_BITS-1:0]     font_idx;
    logic [ROW_BITS-1:0]          row_ok;
    logic [FIELD_BITS-1:0]        top_y;

    function automatic logic signed [XW-1:0] sat(input logic signed [XW-1:0] v,
                                                  input logic signed [XW-1:0] lo,
                                                  input logic signed [XW-1:0] hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    assign in_chan.ready = !full;
    assign accept        = in_chan.valid && !full;

    always_comb
    begin
        sx_ext = XW'(in_chan.start_x);
        sy_ext = XW'(in_chan.start_y);
        if (in_chan.start_of_line)
        begin
            cx_ext = sat(sx_ext, C_MIN, C_MAX);
            cy_ext = sat(sy_ext, C_MIN, C_MAX);
        end
        else
        begin
            cx_ext = XW'(cursor_x_reg);
            cy_ext = XW'(cursor_y_reg);
        end
    end

    always_comb
    begin
        if (in_chan.char_code >= LOWER_A && in_chan.char_code <= LOWER_Z)
            code_fold = in_chan.char_code - CASE_FOLD;
        else
            code_fold = in_chan.char_code;
        drawn    = (code_fold >= FONT_FIRST) && (code_fold < FONT_END);
        font_idx = FONT_IDX_BITS'(code_fold - FONT_FIRST);
    end

    // Rows are clipped once per character; the top y is the same for all columns.
    always_comb
    begin
        height_ext = XW'($signed({1'b0, cfg.height}));
        for (int r = 0; r < ROW_BITS; r++)
        begin
            row_ok[r] = ((cy_ext + XW'(r)) >= 0) && ((cy_ext + XW'(r)) < height_ext);
        end
        top_y = FIELD_BITS'(sat(cy_ext, F_MIN, F_MAX));
    end

    assign push      = accept && drawn;
    assign push_data = {cx_ext[COORD_BITS-1:0], top_y, row_ok, font_glyph(font_idx),
                        in_chan.pixel_color};

    always_comb
    begin
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        if (accept)
        begin
            cursor_x_next = COORD_BITS'(sat(cx_ext + ADVANCE, C_MIN, C_MAX));
            cursor_y_next = COORD_BITS'(cy_ext);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
        end
        else
        begin
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/gtw_fifo.sv -----
// Small register queue between the front and back ends.
// Depends on nothing but its parameters.
`default_nettype none

module gtw_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic                  full,
    output logic                  not_empty,
    output logic [WIDTH-1:0]      head_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [NW-1:0] CNT_FULL = NW'(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign head_data = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ----- hdl/gtw_back.sv -----
// Back end: walks the scaled columns of the queued character, applies the
// column clip and drives the registered output channel. Depends on gtw_pkg, gtw_if.
`default_nettype none

module gtw_back #(
    parameter int GLYPH_SCALE = gtw_pkg::GLYPH_SCALE_DEF,
    parameter int COORD_BITS  = gtw_pkg::COORD_BITS_DEF,
    parameter int ENTRY_W     = 1
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire gtw_pkg::frame_cfg_t cfg,
    input  wire logic               head_valid,
    input  wire logic [ENTRY_W-1:0] head_data,
    output logic                    pop,
    gtw_col_if.source               out_chan
);
    import gtw_pkg::*;

    localparam int XW    = ((COORD_BITS > FIELD_BITS) ? COORD_BITS : FIELD_BITS) + 2;
    localparam int NCOLS = GLYPH_COLS * GLYPH_SCALE;
    localparam int CW    = $clog2(NCOLS);
    localparam int GW    = $clog2(GLYPH_COLS);
    localparam int RW    = (GLYPH_SCALE > 1) ? $clog2(GLYPH_SCALE) : 1;
    localparam logic [CW-1:0] COL_LAST = CW'(NCOLS - 1);
    localparam logic [RW-1:0] REP_LAST = RW'(GLYPH_SCALE - 1);
    localparam logic signed [XW-1:0] F_MAX = XW'((1 << (FIELD_BITS - 1)) - 1);
    localparam logic signed [XW-1:0] F_MIN = XW'(-(1 << (FIELD_BITS - 1)));

    logic signed [COORD_BITS-1:0] cx;
    logic [FIELD_BITS-1:0]        top_y;
    logic [ROW_BITS-1:0]          row_ok;
    logic [GLYPH_BITS-1:0]        glyph;
    logic [COLOR_BITS-1:0]        color;
    logic [GLYPH_COL_BITS-1:0]    glyph_col [GLYPH_COLS];
    logic [GLYPH_COL_BITS-1:0]    col_bits;

    logic [CW-1:0] col_reg, col_next;
    logic [GW-1:0] gcol_reg, gcol_next;
    logic [RW-1:0] rep_reg, rep_next;
    logic          last, step;

    logic signed [XW-1:0]  px, width_ext, px_sat;
    logic                  x_ok;
    logic [ROW_BITS-1:0]   mask;

    logic                  out_valid_reg, out_valid_next;
    logic [FIELD_BITS-1:0] column_x_reg, top_y_reg;
    logic [ROW_BITS-1:0]   row_mask_reg;
    logic [COLOR_BITS-1:0] color_reg;
    logic                  last_reg;

    assign {cx, top_y, row_ok, glyph, color} = head_data;

    always_comb
    begin
        for (int j = 0; j < GLYPH_COLS; j++)
        begin
            glyph_col[j] = glyph[GLYPH_BITS - 1 - j * GLYPH_COL_BITS -: GLYPH_COL_BITS];
        end
    end
    assign col_bits = glyph_col[gcol_reg];

    assign width_ext = XW'($signed({1'b0, cfg.width}));
    assign px        = XW'(cx) + XW'($signed({1'b0, col_reg}));
    assign x_ok      = (px >= 0) && (px < width_ext);
    assign px_sat    = (px < F_MIN) ? F_MIN : ((px > F_MAX) ? F_MAX : px);

    // Each glyph row covers GLYPH_SCALE mask rows; rows past the scaled glyph stay clear.
    for (genvar r = 0; r < ROW_BITS; r++)
    begin : g_row
        if (r < GLYPH_ROWS * GLYPH_SCALE)
        begin : g_on
            assign mask[r] = x_ok && row_ok[r] && col_bits[r / GLYPH_SCALE];
        end
        else
        begin : g_off
            assign mask[r] = 1'b0;
        end
    end

    assign last = (col_reg == COL_LAST);
    assign step = head_valid && (!out_valid_reg || out_chan.ready);
    assign pop  = step && last;

    always_comb
    begin
        col_next  = col_reg;
        gcol_next = gcol_reg;
        rep_next  = rep_reg;
        if (step)
        begin
            if (last)
            begin
                col_next  = '0;
                gcol_next = '0;
                rep_next  = '0;
            end
            else
            begin
                col_next = col_reg + 1'b1;
                if (rep_reg == REP_LAST)
                begin
                    rep_next  = '0;
                    gcol_next = gcol_reg + 1'b1;
                end
                else
                begin
                    rep_next = rep_reg + 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        if (step)
            out_valid_next = 1'b1;
        else if (out_chan.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            gcol_reg      <= '0;
            rep_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            gcol_reg      <= gcol_next;
            rep_reg       <= rep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            column_x_reg <= FIELD_BITS'(px_sat);
            top_y_reg    <= top_y;
            row_mask_reg <= mask;
            color_reg    <= color;
            last_reg     <= last;
        end
    end

    assign out_chan.valid        = out_valid_reg;
    assign out_chan.column_x     = column_x_reg;
    assign out_chan.column_top_y = top_y_reg;
    assign out_chan.row_mask     = row_mask_reg;
    assign out_chan.paint_color  = color_reg;
    assign out_chan.last_column  = last_reg;

endmodule

`default_nettype wire

// ----- hdl/bitmap_text_glyph_writer_core.sv -----
// Glyph writer: 5x7 font, scaled, one column request per cycle if not stalled.
//
// in_chan takes one character request per handshake: an optional cursor restart
// (start_of_line with start_x, start_y), the raw code and the paint color.
// Lower-case letters fold to upper case; codes 32..95 draw a glyph, all others
// draw nothing. Every character moves the cursor right by 6*GLYPH_SCALE pixels.
// out_chan gives 5*GLYPH_SCALE column requests per drawn character (ten at the
// default scale), one per cycle, the final one flagged by last_column.
// The front end takes a character every cycle while its two-entry queue has room;
// the back end's column counter walks every column of one drawn character before
// it pops the next, and characters that draw nothing never enter the queue.
// A character's first column request passes the queue, then the output register.
// When out_chan stalls, the output register holds its request and the back end
// waits; the queue then fills and in_chan.ready drops.
// Reset clears the cursor to 0,0, empties the queue and sets the frame size to
// 640 by 480. The APB port holds frame_width at 0x0 and frame_height at 0x4;
// write them only while no character is in flight.
`default_nettype none

module bitmap_text_glyph_writer_core #(
    parameter int GLYPH_SCALE = gtw_pkg::GLYPH_SCALE_DEF,
    parameter int COORD_BITS  = gtw_pkg::COORD_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    gtw_char_if.sink                               in_chan,
    gtw_col_if.source                              out_chan,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [gtw_pkg::APB_ADDR_BITS-1:0] paddr,
    input  wire logic [gtw_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic      [gtw_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                                   pready
);
    import gtw_pkg::*;

    localparam int ENTRY_W = COORD_BITS + FIELD_BITS + ROW_BITS + GLYPH_BITS + COLOR_BITS;

    frame_cfg_t          cfg_reg, cfg_next;
    reg_index_t          reg_sel;
    logic                wr_en;
    logic                push, pop, full, not_empty;
    logic [ENTRY_W-1:0]  push_data, head_data;

    assign pready  = 1'b1;
    assign reg_sel = reg_index_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_FRAME_WIDTH:  cfg_next.width  = pwdata[DIM_BITS-1:0];
                REG_FRAME_HEIGHT: cfg_next.height = pwdata[DIM_BITS-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_FRAME_WIDTH:  prdata = APB_DATA_BITS'(cfg_reg.width);
            REG_FRAME_HEIGHT: prdata = APB_DATA_BITS'(cfg_reg.height);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width  <= FRAME_WIDTH_RST;
            cfg_reg.height <= FRAME_HEIGHT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    gtw_front #(
        .GLYPH_SCALE (GLYPH_SCALE),
        .COORD_BITS  (COORD_BITS),
        .ENTRY_W     (ENTRY_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_chan   (in_chan),
        .cfg       (cfg_reg),
        .full      (full),
        .push      (push),
        .push_data (push_data)
    );

    gtw_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (full),
        .not_empty (not_empty),
        .head_data (head_data)
    );

    gtw_back #(
        .GLYPH_SCALE (GLYPH_SCALE),
        .COORD_BITS  (COORD_BITS),
        .ENTRY_W     (ENTRY_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (not_empty),
        .head_data  (head_data),
        .pop        (pop),
        .out_chan   (out_chan)
    );

endmodule

`default_nettype wire

// ----- hdl/gtw_core_chk.sv -----
// Port-level checker for the glyph writer core, attached by the bind below.
// Depends on gtw_pkg for widths.
`default_nettype none

module gtw_core_chk (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              out_valid,
    input wire logic                              out_ready,
    input wire logic [gtw_pkg::FIELD_BITS-1:0]    column_x,
    input wire logic [gtw_pkg::ROW_BITS-1:0]      row_mask,
    input wire logic                              psel,
    input wire logic                              penable,
    input wire logic                              pwrite,
    input wire logic [gtw_pkg::APB_ADDR_BITS-1:0] paddr,
    input wire logic [gtw_pkg::APB_DATA_BITS-1:0] pwdata,
    input wire logic [gtw_pkg::APB_DATA_BITS-1:0] prdata,
    input wire logic                              pready
);
    import gtw_pkg::*;

    // A stalled column request keeps its position and pixels.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(column_x) && $stable(row_mask))
        else $error("column request changed while stalled");

    // A column left of the frame never paints.
    a_left_clip: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && column_x[FIELD_BITS-1] |-> row_mask == '0)
        else $error("pixels painted at negative x");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

    // A frame width write is visible on the very next read.
    a_width_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && !paddr[2]
        |=> !(psel && !pwrite && !paddr[2]) ||
            prdata[DIM_BITS-1:0] == $past(pwdata[DIM_BITS-1:0]))
        else $error("frame width read back wrong");

endmodule

bind bitmap_text_glyph_writer_core gtw_core_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .column_x  (out_chan.column_x),
    .row_mask  (out_chan.row_mask),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
);

`default_nettype wire
